FILE: rtl/qds_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qds_pkg: shared types and constants of the quadrature decoder
// Field widths, event codes, register indexes and reset values, saturation
// limits, the x4 step table and the channel and divider status structs.
// ----------------------------------------------------------------------------
package qds_pkg;

	// field widths
	localparam int MODE_W  = 2;
	localparam int TS_W    = 32;
	localparam int POS_W   = 32;
	localparam int SCALE_W = 20;
	// |count diff| <= 2^31, times a 20-bit scale
	localparam int PROD_W  = POS_W - 1 + SCALE_W;
	// quotient bits left once overflow is ruled out
	localparam int QUO_W   = POS_W - 1;

	// event codes
	localparam logic [MODE_W-1:0] MODE_EDGE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_TICK = 2'd1;
	localparam logic [MODE_W-1:0] MODE_INIT = 2'd2;

	// configuration registers
	localparam int                 CFG_IDX_W   = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b1;
	localparam logic [SCALE_W-1:0] SCALE_RST   = 20'd100000;
	localparam logic [SCALE_W-1:0] TIMEOUT_RST = 20'd9000;

	// saturation limits
	localparam logic [POS_W-1:0] SPEED_MAX = 32'h7FFF_FFFF;
	localparam logic [POS_W-1:0] SPEED_MIN = 32'h8000_0000;

	// x4 decode: index is {prev A, prev B, new A, new B}, 2-bit signed step
	localparam logic [1:0] STEP_TBL [16] = '{
		2'b00, 2'b11, 2'b01, 2'b00,
		2'b01, 2'b00, 2'b00, 2'b11,
		2'b11, 2'b00, 2'b00, 2'b01,
		2'b00, 2'b01, 2'b11, 2'b00
	};

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              phase_a;
		logic              phase_b;
		logic [TS_W-1:0]   timestamp;
	} qds_item_t;

	typedef struct packed {
		logic signed [POS_W-1:0] position;
		logic signed [POS_W-1:0] velocity;
	} qds_result_t;

	// divider status toward the control
	typedef struct packed {
		logic             done;
		logic             ovf;
		logic [QUO_W-1:0] quo;
	} qds_div_res_t;

endpackage
`default_nettype wire

FILE: rtl/qds_item_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qds_item_if: event channel into the decoder
// Valid/ready handshake carrying one encoder event per transfer.
// ----------------------------------------------------------------------------
interface qds_item_if import qds_pkg::*; ();
	logic      valid;
	logic      ready;
	qds_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/qds_result_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qds_result_if: result channel out of the decoder
// Valid/ready handshake carrying position and velocity per transfer.
// ----------------------------------------------------------------------------
interface qds_result_if import qds_pkg::*; ();
	logic        valid;
	logic        ready;
	qds_result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/quadrature_decoder_with_speed.sv
`default_nettype none
// ----------------------------------------------------------------------------
// quadrature_decoder_with_speed: x4 quadrature decoder with speed estimate
// Decodes A/B events into a wrapping position count and a saturated
// velocity in counts per second from serial multiply and divide units.
// ----------------------------------------------------------------------------
// Usage:
//   item    - one event per transfer: mode (edge, sample tick, init), the
//             A/B levels and a timestamp.
//   result  - exactly one transfer per event: position and velocity after it.
//   cfg_*   - write port for speed_scale (index 0) and idle_timeout_ticks
//             (index 1); write only while the block is idle.
// Ticks, inits and edges with no armed sample are done in the accept
//   cycle; the result is valid on the next cycle.
// An edge with an armed sample passes the DIFF and LOAD states, a
//   bit-serial multiply over the 20 scale bits and a bit-serial divide
//   that develops the 31-bit quotient (skipped when the quotient
//   overflows), then FIN, which loads the output register once it is free.
// One event is in work at a time; a new one is taken while the sequencer
//   is idle and the output register is empty or being drained.
// Reset clears position, velocity, arming and the last sample; the
//   registers return to 100000 and 9000.
// A stalled result holds in the output register and blocks further events.
// ----------------------------------------------------------------------------
module quadrature_decoder_with_speed import qds_pkg::*; #(
	parameter int TIME_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	qds_item_if.sink             item,
	qds_result_if.source         result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [SCALE_W-1:0]   cfg_wdata
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIFF = 3'd1;
	localparam logic [2:0] ST_LOAD = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	// configuration
	logic [SCALE_W-1:0] scale_q;
	logic [SCALE_W-1:0] timeout_q;

	// decoder state
	logic [2:0]           st_q;
	logic [1:0]           prev_q;
	logic [POS_W-1:0]     count_q;
	logic                 armed_q;
	logic [POS_W-1:0]     last_count_q;
	logic [TIME_BITS-1:0] last_time_q;
	logic [POS_W-1:0]     speed_q;
	logic [POS_W-1:0]     diff_q;
	logic [TIME_BITS-1:0] divisor_q;

	// output register
	logic        res_valid_q;
	qds_result_t res_data_q;

	logic                        accept;
	logic                        out_free;
	logic                        long_item;
	logic [1:0]                  pair;
	logic [1:0]                  step;
	logic [POS_W-1:0]            count_step;
	logic [TIME_BITS+TS_W-1:0]   ts_wide;
	logic [TIME_BITS-1:0]        ts_now;
	logic [TIME_BITS-1:0]        elapsed;
	logic [TIME_BITS-1:0]        divisor;
	logic [TIME_BITS+SCALE_W-1:0] el_wide;
	logic [TIME_BITS+SCALE_W-1:0] to_wide;
	logic                        timed_out;
	logic [POS_W-1:0]            nxt_count;
	logic [POS_W-1:0]            nxt_speed;
	logic [POS_W-1:0]            mag;
	logic [POS_W-1:0]            quo_ext;
	logic [POS_W-1:0]            div_speed;

	logic               mul_start;
	logic               mul_done;
	logic [PROD_W-1:0]  prod;
	logic               div_start;
	qds_div_res_t       div_res;

	// handshake
	assign out_free   = !res_valid_q || result.ready;
	assign item.ready = (st_q == ST_IDLE) && out_free;
	assign accept     = item.valid && item.ready;
	assign long_item  = (item.data.mode == MODE_EDGE) && armed_q;

	// x4 step decode
	assign pair       = {item.data.phase_a, item.data.phase_b};
	assign step       = STEP_TBL[{prev_q, pair}];
	assign count_step = count_q + {{(POS_W-2){step[1]}}, step};

	// elapsed ticks, modulo 2^TIME_BITS and read as signed
	assign ts_wide = {{TIME_BITS{1'b0}}, item.data.timestamp};
	assign ts_now  = ts_wide[TIME_BITS-1:0];
	assign elapsed = ts_now - last_time_q;
	assign divisor = (!elapsed[TIME_BITS-1] && (elapsed != '0)) ? elapsed
		: TIME_BITS'(1);
	assign el_wide   = {{SCALE_W{1'b0}}, elapsed};
	assign to_wide   = {{TIME_BITS{1'b0}}, timeout_q};
	assign timed_out = !elapsed[TIME_BITS-1] && (el_wide >= to_wide);

	// count and speed after a short event
	always_comb begin
		nxt_count = count_q;
		nxt_speed = speed_q;
		case (item.data.mode)
			MODE_EDGE: nxt_count = count_step;
			MODE_TICK: begin
				if (armed_q && timed_out) nxt_speed = '0;
			end
			MODE_INIT: nxt_count = '0;
			default: ;
		endcase
	end

	// serial units
	assign mag       = diff_q[POS_W-1] ? (~diff_q + 1'b1) : diff_q;
	assign mul_start = (st_q == ST_LOAD);
	assign div_start = (st_q == ST_MUL) && mul_done;

	qds_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.mag    (mag),
		.scale  (scale_q),
		.done   (mul_done),
		.prod   (prod)
	);

	qds_div #(
		.DW (TIME_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (prod),
		.den    (divisor_q),
		.res    (div_res)
	);

	// signed, saturated speed from the divider
	assign quo_ext = {1'b0, div_res.quo};
	always_comb begin
		if (div_res.ovf) begin
			div_speed = diff_q[POS_W-1] ? SPEED_MIN : SPEED_MAX;
		end else begin
			div_speed = diff_q[POS_W-1] ? (~quo_ext + 1'b1) : quo_ext;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q   <= SCALE_RST;
			timeout_q <= TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_SCALE:   scale_q   <= cfg_wdata;
				CFG_TIMEOUT: timeout_q <= cfg_wdata;
			endcase
		end
	end

	// sequencer and decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_IDLE;
			prev_q       <= '0;
			count_q      <= '0;
			armed_q      <= 1'b0;
			last_count_q <= '0;
			last_time_q  <= '0;
			speed_q      <= '0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (accept) begin
						count_q <= nxt_count;
						speed_q <= nxt_speed;
						if (item.data.mode == MODE_EDGE || item.data.mode == MODE_INIT) begin
							prev_q <= pair;
						end
						if (item.data.mode == MODE_TICK && !armed_q) begin
							armed_q <= 1'b1;
						end
						if (long_item) begin
							armed_q     <= 1'b0;
							last_time_q <= ts_now;
							st_q        <= ST_DIFF;
						end
					end
				end
				ST_DIFF: begin
					last_count_q <= count_q;
					st_q         <= ST_LOAD;
				end
				ST_LOAD: st_q <= ST_MUL;
				ST_MUL: begin
					if (mul_done) st_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_res.done) begin
						speed_q <= div_speed;
						st_q    <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// operands of the speed calculation
	always_ff @(posedge clk) begin
		if (accept && long_item) divisor_q <= divisor;
		if (st_q == ST_DIFF) diff_q <= count_q - last_count_q;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if ((accept && !long_item) || (st_q == ST_FIN && out_free)) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !long_item) begin
			res_data_q.position <= nxt_count;
			res_data_q.velocity <= nxt_speed;
		end else if (st_q == ST_FIN && out_free) begin
			res_data_q.position <= count_q;
			res_data_q.velocity <= speed_q;
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_data_q;

	// checks
	a_mul_done_in_mul: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> st_q == ST_MUL)
		else $error("multiplier finished outside its phase");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> st_q == ST_DIV)
		else $error("divider finished outside its phase");

	a_armed_edge_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && long_item) |=> (st_q == ST_DIFF) && !armed_q)
		else $error("armed edge did not start a speed update");

	a_busy_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_IDLE) |-> !item.ready)
		else $error("event taken while a speed update is in work");

endmodule
`default_nettype wire

FILE: rtl/qds_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qds_mul: bit-serial unsigned multiplier
// Shift-add over the scale, MSB first, one scale bit per cycle.
// ----------------------------------------------------------------------------
module qds_mul import qds_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [POS_W-1:0]   mag,
	input  logic [SCALE_W-1:0] scale,
	output logic               done,
	output logic [PROD_W-1:0]  prod
);

	localparam int CNT_W = $clog2(SCALE_W + 1);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [SCALE_W-1:0] sc_q;
	logic [POS_W-1:0]   mag_q;
	logic [PROD_W-1:0]  acc_q;
	logic [PROD_W-1:0]  addend;

	assign addend = sc_q[SCALE_W-1] ? {{(PROD_W-POS_W){1'b0}}, mag_q} : '0;

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(SCALE_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// accumulate: acc = 2*acc + bit*mag
	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= mag;
			sc_q  <= scale;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= {acc_q[PROD_W-2:0], 1'b0} + addend;
			sc_q  <= {sc_q[SCALE_W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule
`default_nettype wire

FILE: rtl/qds_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qds_div: bit-serial restoring divider with overflow check
// Flags a quotient of 2^31 or more up front, else develops the 31-bit
// quotient one bit per cycle.
// ----------------------------------------------------------------------------
module qds_div import qds_pkg::*; #(
	parameter int DW = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PROD_W-1:0] num,
	input  logic [DW-1:0]     den,
	output qds_div_res_t      res
);

	localparam int HI_W  = PROD_W - QUO_W;
	localparam int CNT_W = $clog2(QUO_W + 1);

	logic              busy_q;
	logic              done_q;
	logic              ovf_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DW-1:0]     d_q;
	logic [DW-1:0]     r_q;
	logic [QUO_W-1:0]  lo_q;

	logic [DW+HI_W-1:0] hi_wide;
	logic [DW+HI_W-1:0] den_wide;
	logic               ovf;
	logic [DW:0]        trial;
	logic [DW:0]        trial_sub;
	logic               ge;

	// num >= den * 2^31 exactly when num's upper bits reach den
	assign hi_wide  = {{DW{1'b0}}, num[PROD_W-1:QUO_W]};
	assign den_wide = {{HI_W{1'b0}}, den};
	assign ovf      = hi_wide >= den_wide;

	// one restoring step
	assign trial     = {r_q, lo_q[QUO_W-1]};
	assign trial_sub = trial - {1'b0, d_q};
	assign ge        = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ovf_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				ovf_q <= ovf;
				if (ovf) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= CNT_W'(QUO_W);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// partial remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			d_q  <= den;
			r_q  <= hi_wide[DW-1:0];
			lo_q <= num[QUO_W-1:0];
		end else if (busy_q) begin
			r_q  <= ge ? trial_sub[DW-1:0] : trial[DW-1:0];
			lo_q <= {lo_q[QUO_W-2:0], ge};
		end
	end

	assign res.done = done_q;
	assign res.ovf  = ovf_q;
	assign res.quo  = lo_q;

endmodule
`default_nettype wire

FILE: tb/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb: self-checking bench for quadrature_decoder_with_speed
// Feeds encoder events through the item channel and checks every position
// and velocity transfer against a behavioral model kept in the bench.
// Directed events come first, then a one-way run at full scale that ends in
// one-tick intervals both ways, then random phases under several register
// settings. Random idling runs on both sides, and one long receiver
// hold-off makes the block back up into its input.
// ----------------------------------------------------------------------------
module tb import qds_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 70;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [SCALE_W-1:0] cfg_wdata;

	qds_item_if item_ch ();
	qds_result_if result_ch ();

	quadrature_decoder_with_speed DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	// events waiting to go out, and position/velocity pairs still owed
	qds_item_t pending_events[$];
	qds_result_t expected_results[$];

	// decoder model state and registers
	logic [1:0] pm_prev;
	logic [31:0] pm_count;
	logic pm_armed;
	logic [31:0] pm_last_count;
	logic [31:0] pm_last_time;
	logic [31:0] pm_speed;
	logic [SCALE_W-1:0] pm_scale;
	logic [SCALE_W-1:0] pm_timeout;

	// stimulus generator state
	logic [1:0] gen_pins;
	logic [31:0] gen_time;
	bit gen_dir;

	// handshake pacing
	bit src_lazy;
	bit dst_lazy;
	int src_wait;
	int dst_wait;
	logic hold_start;
	int hold_left;

	int err_cnt;
	int n_events;
	int n_speed;
	int n_sat;
	int n_zeroed;

	// position of an A/B pair along the forward sequence 00, 10, 11, 01
	function automatic logic [1:0] pair_pos(input logic [1:0] pair);
		return {pair[0], pair[1] ^ pair[0]};
	endfunction

	function automatic logic [1:0] pins_at(input logic [1:0] pos);
		return {pos[1] ^ pos[0], pos[1]};
	endfunction

	// model one event: update the state, return position and velocity
	function automatic qds_result_t decode_event(input qds_item_t ev);
		logic [1:0] pair;
		logic [1:0] move;
		logic signed [31:0] span32;
		logic signed [31:0] dcount;
		longint dt;
		longint prod;
		longint quo;
		qds_result_t res;
		pair = {ev.phase_a, ev.phase_b};
		span32 = ev.timestamp - pm_last_time;
		dt = span32;
		n_events++;
		case (ev.mode)
			MODE_EDGE: begin
				move = pair_pos(pair) - pair_pos(pm_prev);
				if (move == 2'd1)
					pm_count = pm_count + 32'd1;
				else if (move == 2'd3)
					pm_count = pm_count - 32'd1;
				pm_prev = pair;
				if (pm_armed) begin
					pm_armed = 1'b0;
					if (dt < 1)
						dt = 1;
					dcount = pm_count - pm_last_count;
					prod = longint'(dcount) * longint'(pm_scale);
					quo = prod / dt;
					n_speed++;
					if (quo > 64'sd2147483647) begin
						quo = 64'sd2147483647;
						n_sat++;
					end else if (quo < -64'sd2147483648) begin
						quo = -64'sd2147483648;
						n_sat++;
					end
					pm_speed = quo[31:0];
					pm_last_count = pm_count;
					pm_last_time = ev.timestamp;
				end
			end
			MODE_TICK: begin
				if (!pm_armed) begin
					pm_armed = 1'b1;
				end else if (dt >= longint'(pm_timeout)) begin
					pm_speed = '0;
					n_zeroed++;
				end
			end
			MODE_INIT: begin
				pm_prev = pair;
				pm_count = '0;
			end
			default: begin
				// spare code leaves everything as it is
			end
		endcase
		res.position = pm_count;
		res.velocity = pm_speed;
		return res;
	endfunction

	task automatic queue_event(input logic [MODE_W-1:0] m, input logic [1:0] pins,
			input logic [31:0] ts);
		qds_item_t ev;
		ev.mode = m;
		ev.phase_a = pins[1];
		ev.phase_b = pins[0];
		ev.timestamp = ts;
		if (m == MODE_EDGE || m == MODE_INIT)
			gen_pins = pins;
		pending_events.push_back(ev);
	endtask

	task automatic flag_error(input string msg);
		err_cnt++;
		if (err_cnt <= 10)
			$display("MISMATCH: %s", msg);
	endtask

	// both registers are written back to back; called only while idle
	task automatic set_regs(input logic [SCALE_W-1:0] scale, input logic [SCALE_W-1:0] tmo);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= CFG_SCALE;
		cfg_wdata <= scale;
		@(posedge clk);
		cfg_idx <= CFG_TIMEOUT;
		cfg_wdata <= tmo;
		@(posedge clk);
		cfg_we <= 1'b0;
		pm_scale = scale;
		pm_timeout = tmo;
	endtask

	// wait until every event went out and every result came back
	task automatic drain();
		@(negedge clk);
		while (pending_events.size() != 0 || item_ch.valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// mostly clean x4 sequences with random timing, plus ticks and noise
	task automatic queue_random(input int n);
		int r;
		int k;
		logic [1:0] pins;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if ($urandom_range(0, 19) == 0)
				gen_time = $urandom();
			else if ($urandom_range(0, 29) == 0)
				gen_time = gen_time - $urandom_range(1, 5000);
			else
				gen_time = gen_time + $urandom_range(0, 400);
			if (r < 68) begin
				k = $urandom_range(0, 19);
				if ($urandom_range(0, 15) == 0)
					gen_dir = ~gen_dir;
				if (k == 0)
					pins = gen_pins;
				else if (k == 1)
					pins = pins_at(pair_pos(gen_pins) + 2'd2);
				else
					pins = pins_at(pair_pos(gen_pins) + (gen_dir ? 2'd1 : 2'd3));
				queue_event(MODE_EDGE, pins, gen_time);
			end else if (r < 86) begin
				if ($urandom_range(0, 2) == 0)
					gen_time = gen_time + $urandom_range(0, 12000);
				pins = 2'($urandom_range(0, 3));
				queue_event(MODE_TICK, pins, gen_time);
			end else if (r < 91) begin
				pins = 2'($urandom_range(0, 3));
				queue_event(MODE_INIT, pins, gen_time);
			end else if (r < 94) begin
				pins = 2'($urandom_range(0, 3));
				queue_event(MODE_SPARE, pins, gen_time);
			end else begin
				pins = 2'($urandom_range(0, 3));
				queue_event(MODE_EDGE, pins, gen_time);
			end
		end
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// event driver: one transfer per event, random gap after each when src_lazy is set
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			item_ch.data <= '0;
			src_wait <= 0;
		end else begin
			if (item_ch.valid && item_ch.ready)
				expected_results.push_back(decode_event(item_ch.data));
			if (!item_ch.valid || item_ch.ready) begin
				if (src_wait != 0) begin
					item_ch.valid <= 1'b0;
					src_wait <= src_wait - 1;
				end else if (pending_events.size() != 0) begin
					item_ch.data <= pending_events.pop_front();
					item_ch.valid <= 1'b1;
					src_wait <= src_lazy ? $urandom_range(0, 12) : 0;
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_left <= 0;
		else if (hold_start)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// result monitor and checker
	always @(posedge clk or negedge arst_n) begin
		int w;
		qds_result_t want;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			dst_wait <= 0;
		end else begin
			w = dst_wait;
			if (result_ch.valid && result_ch.ready) begin
				if (expected_results.size() == 0) begin
					flag_error($sformatf("unexpected transfer: pos %0d vel %0d",
						result_ch.data.position, result_ch.data.velocity));
				end else begin
					want = expected_results.pop_front();
					if (result_ch.data.position !== want.position ||
							result_ch.data.velocity !== want.velocity)
						flag_error($sformatf("pos exp %0d got %0d, vel exp %0d got %0d",
							want.position, result_ch.data.position,
							want.velocity, result_ch.data.velocity));
				end
				w = dst_lazy ? $urandom_range(0, 12) : 0;
			end
			if (hold_left != 0) begin
				result_ch.ready <= 1'b0;
				dst_wait <= w;
			end else if (w != 0) begin
				result_ch.ready <= 1'b0;
				dst_wait <= w - 1;
			end else begin
				result_ch.ready <= 1'b1;
				dst_wait <= 0;
			end
		end
	end

	// run limit
	initial begin
		#6_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// stimulus sequence
	initial begin
		logic [31:0] t0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		hold_start = 1'b0;
		src_lazy = 1'b1;
		dst_lazy = 1'b1;
		err_cnt = 0;
		n_events = 0;
		n_speed = 0;
		n_sat = 0;
		n_zeroed = 0;
		pm_prev = '0;
		pm_count = '0;
		pm_armed = 1'b0;
		pm_last_count = '0;
		pm_last_time = '0;
		pm_speed = '0;
		pm_scale = SCALE_RST;
		pm_timeout = TIMEOUT_RST;
		gen_pins = 2'b00;
		gen_time = '0;
		gen_dir = 1'b1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed events at the reset register values
		queue_event(MODE_TICK, 2'b00, 32'd0);          // arm
		queue_event(MODE_EDGE, 2'b10, 32'd0);          // +1, zero elapsed clamps to one
		queue_event(MODE_EDGE, 2'b11, 32'd100);
		queue_event(MODE_EDGE, 2'b01, 32'd200);
		queue_event(MODE_EDGE, 2'b00, 32'd300);
		queue_event(MODE_EDGE, 2'b00, 32'd310);        // no move
		queue_event(MODE_EDGE, 2'b11, 32'd320);        // double step, ignored
		queue_event(MODE_EDGE, 2'b00, 32'd330);
		queue_event(MODE_EDGE, 2'b01, 32'd340);        // backward
		queue_event(MODE_TICK, 2'b01, 32'd1000);
		queue_event(MODE_EDGE, 2'b00, 32'd2000);       // speed from a real interval
		queue_event(MODE_TICK, 2'b11, 32'd2100);
		queue_event(MODE_TICK, 2'b11, 32'h8000_07D0);  // negative elapsed keeps speed
		queue_event(MODE_TICK, 2'b00, 32'd10999);      // one short of timeout
		queue_event(MODE_TICK, 2'b00, 32'd11000);      // timeout zeroes speed
		queue_event(MODE_SPARE, 2'b11, 32'hFFFF_FFFF);
		queue_event(MODE_INIT, 2'b11, 32'd11001);
		queue_event(MODE_EDGE, 2'b01, 32'd11005);      // negative speed
		queue_event(MODE_TICK, 2'b10, 32'hFFFF_FFF0);
		queue_event(MODE_EDGE, 2'b00, 32'h0000_0010);  // negative elapsed on an edge
		queue_event(MODE_TICK, 2'b00, 32'd20);
		queue_event(MODE_EDGE, 2'b10, 32'h8000_000F);  // largest positive elapsed
		queue_event(MODE_SPARE, 2'b00, 32'd0);
		drain();

		// one-way run at full scale, then one-tick intervals both ways
		src_lazy = 1'b0;
		dst_lazy = 1'b0;
		set_regs({SCALE_W{1'b1}}, {SCALE_W{1'b1}});
		t0 = 32'd5000;
		queue_event(MODE_INIT, 2'b00, t0);
		queue_event(MODE_TICK, 2'b00, t0);
		queue_event(MODE_TICK, 2'b00, t0);
		queue_event(MODE_EDGE, 2'b10, t0);
		for (int i = 0; i < 300; i++)
			queue_event(MODE_EDGE, pins_at(pair_pos(gen_pins) + 2'd1), t0 + 32'd500);
		queue_event(MODE_TICK, gen_pins, t0);
		queue_event(MODE_EDGE, pins_at(pair_pos(gen_pins) + 2'd1), t0 + 32'd1);
		queue_event(MODE_TICK, gen_pins, t0 + 32'd1);
		queue_event(MODE_INIT, gen_pins, t0 + 32'd1);
		queue_event(MODE_EDGE, pins_at(pair_pos(gen_pins) + 2'd1), t0 + 32'd2);
		drain();

		// zero scale and zero timeout
		src_lazy = 1'b1;
		dst_lazy = 1'b1;
		set_regs('0, '0);
		queue_random(80);
		drain();

		// smallest nonzero registers
		set_regs(20'd1, 20'd1);
		queue_random(80);
		drain();

		// random scale, short timeouts, with a long receiver hold-off
		set_regs(SCALE_W'($urandom_range(1, (1 << SCALE_W) - 1)),
			SCALE_W'($urandom_range(1, 5000)));
		queue_random(200);
		@(posedge clk);
		hold_start <= 1'b1;
		@(posedge clk);
		hold_start <= 1'b0;
		drain();

		// fully random registers
		src_lazy = $urandom_range(0, 1);
		set_regs(SCALE_W'($urandom()), SCALE_W'($urandom()));
		queue_random(80);
		drain();

		// reset values again, back-to-back transfers
		src_lazy = 1'b0;
		dst_lazy = 1'b0;
		set_regs(SCALE_RST, TIMEOUT_RST);
		queue_random(80);
		drain();

		$display("Run covered %0d events in seven phases: %0d speed updates, %0d saturated,",
			n_events, n_speed, n_sat);
		$display("%0d idle zeroings, one receiver hold-off of %0d cycles",
			n_zeroed, HOLD_CYCLES);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire

FILE: quadrature_decoder_with_speed.f
rtl/qds_pkg.sv
rtl/qds_item_if.sv
rtl/qds_result_if.sv
rtl/qds_mul.sv
rtl/qds_div.sv
rtl/quadrature_decoder_with_speed.sv
tb/tb.sv
